// ===== rtl/core/radar_sensor_link_codec_macros.svh =====
// Assertion macros shared by the codec modules.
`ifndef RADAR_SENSOR_LINK_CODEC_MACROS_SVH
`define RADAR_SENSOR_LINK_CODEC_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rslc_pkg.sv =====
// Package: payload types, frame constants and command table of the sensor link codec.
package rslc_pkg;

    // Input beat
    typedef struct packed {
        logic        func;
        logic [7:0]  rx_byte;
        logic [3:0]  request_op;
        logic [15:0] request_value;
    } item_t;

    // Result beat
    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        enabled;
        logic [15:0] answer_value;
    } result_t;

    // Work handed from the decoder to the emitter
    typedef struct packed {
        logic        valid;
        logic        is_frame;
        logic [7:0]  cmd;
        logic [7:0]  arg_h;
        logic [7:0]  arg_l;
        logic [7:0]  chk;
        logic [1:0]  kind;
        logic        enabled;
        logic [15:0] value;
    } job_t;

    // Status from the emitter back to the front
    typedef struct packed {
        logic free;
    } emit_status_t;

    localparam logic       FUNC_RX  = 1'b0;
    localparam logic       FUNC_REQ = 1'b1;

    localparam logic [1:0] KIND_TX  = 2'd0;
    localparam logic [1:0] KIND_EN  = 2'd1;
    localparam logic [1:0] KIND_VAL = 2'd2;

    localparam logic [1:0] AWAIT_NONE = 2'd0;
    localparam logic [1:0] AWAIT_EN   = 2'd1;
    localparam logic [1:0] AWAIT_VAL  = 2'd2;

    localparam logic [7:0] HEAD0_BYTE = 8'h55;
    localparam logic [7:0] HEAD1_BYTE = 8'h5A;
    localparam logic [7:0] TAIL_BYTE  = 8'hFE;

    localparam int         FRAME_LEN = 7;
    localparam logic [2:0] LAST_IDX  = 3'(FRAME_LEN - 1);

    // Request operations
    localparam logic [3:0] OP_RADAR_EN_GET = 4'd0;
    localparam logic [3:0] OP_RADAR_EN_SET = 4'd1;
    localparam logic [3:0] OP_DIST_GET     = 4'd2;
    localparam logic [3:0] OP_DIST_SET     = 4'd3;
    localparam logic [3:0] OP_DELAY_GET    = 4'd4;
    localparam logic [3:0] OP_DELAY_SET    = 4'd5;
    localparam logic [3:0] OP_LIGHT_EN_GET = 4'd6;
    localparam logic [3:0] OP_LIGHT_EN_SET = 4'd7;
    localparam logic [3:0] OP_LIGHT_HI_GET = 4'd8;
    localparam logic [3:0] OP_LIGHT_HI_SET = 4'd9;
    localparam logic [3:0] OP_LIGHT_LO_GET = 4'd10;
    localparam logic [3:0] OP_LIGHT_LO_SET = 4'd11;

    // Command bytes
    localparam logic [7:0] CMD_RADAR_EN_GET = 8'h89;
    localparam logic [7:0] CMD_RADAR_EN_SET = 8'h09;
    localparam logic [7:0] CMD_DIST_GET     = 8'h81;
    localparam logic [7:0] CMD_DIST_SET     = 8'h01;
    localparam logic [7:0] CMD_DELAY_GET    = 8'h82;
    localparam logic [7:0] CMD_DELAY_SET    = 8'h02;
    localparam logic [7:0] CMD_LIGHT_EN_GET = 8'h83;
    localparam logic [7:0] CMD_LIGHT_EN_SET = 8'h03;
    localparam logic [7:0] CMD_LIGHT_HI_GET = 8'h84;
    localparam logic [7:0] CMD_LIGHT_HI_SET = 8'h04;
    localparam logic [7:0] CMD_LIGHT_LO_GET = 8'h85;
    localparam logic [7:0] CMD_LIGHT_LO_SET = 8'h05;

    localparam logic [15:0] DIST_MAX  = 16'd15;
    localparam logic [15:0] LIGHT_MAX = 16'd1023;

    // Frame length counter saturates here
    localparam logic [3:0] COUNT_MAX = 4'd15;

    // Command byte for an operation (codes past the table map to zero)
    function automatic logic [7:0] cmd_code(input logic [3:0] op);
        logic [7:0] c;
        unique case (op)
            OP_RADAR_EN_GET: c = CMD_RADAR_EN_GET;
            OP_RADAR_EN_SET: c = CMD_RADAR_EN_SET;
            OP_DIST_GET:     c = CMD_DIST_GET;
            OP_DIST_SET:     c = CMD_DIST_SET;
            OP_DELAY_GET:    c = CMD_DELAY_GET;
            OP_DELAY_SET:    c = CMD_DELAY_SET;
            OP_LIGHT_EN_GET: c = CMD_LIGHT_EN_GET;
            OP_LIGHT_EN_SET: c = CMD_LIGHT_EN_SET;
            OP_LIGHT_HI_GET: c = CMD_LIGHT_HI_GET;
            OP_LIGHT_HI_SET: c = CMD_LIGHT_HI_SET;
            OP_LIGHT_LO_GET: c = CMD_LIGHT_LO_GET;
            OP_LIGHT_LO_SET: c = CMD_LIGHT_LO_SET;
            default:         c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/rslc_decoder.sv =====
// Decoder: link state, request framing and received-frame checking at beat accept.
`include "radar_sensor_link_codec_macros.svh"

module rslc_decoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  rslc_pkg::item_t item,
    output rslc_pkg::job_t  job
);
    import rslc_pkg::*;

    logic [1:0] awaited_reg, awaited_next;
    logic [3:0] byte_count_reg, byte_count_next;
    logic [7:0] fields_reg [4];

    logic       is_rx;
    logic       is_req;
    logic       op_ok;
    logic       is_enable;
    logic [15:0] set_val;
    logic [7:0] req_h;
    logic [7:0] req_l;
    logic [7:0] req_cmd;
    logic [3:0] wpos;
    logic       field_we;
    logic       is_tail;
    logic       frame_ok;
    logic       cmd_en_class;
    logic       cmd_val_class;

    assign is_rx  = accept && (item.func == FUNC_RX);
    assign is_req = accept && (item.func == FUNC_REQ);
    assign op_ok  = (item.request_op <= OP_LIGHT_LO_SET);

    assign is_enable = (item.request_op == OP_RADAR_EN_GET) || (item.request_op == OP_RADAR_EN_SET)
                    || (item.request_op == OP_LIGHT_EN_GET) || (item.request_op == OP_LIGHT_EN_SET);
    assign req_cmd = cmd_code(item.request_op);

    // Argument bytes of a request, with clamping
    always_comb
    begin
        set_val = item.request_value;
        if ((item.request_op == OP_DIST_SET) && (set_val > DIST_MAX))
        begin
            set_val = DIST_MAX;
        end
        if (((item.request_op == OP_LIGHT_HI_SET) || (item.request_op == OP_LIGHT_LO_SET))
            && (set_val > LIGHT_MAX))
        begin
            set_val = LIGHT_MAX;
        end
        req_h = 8'h00;
        req_l = 8'h00;
        if (item.request_op[0])
        begin
            if (is_enable)
            begin
                req_l = {7'd0, |item.request_value};
            end
            else
            begin
                req_h = set_val[15:8];
                req_l = set_val[7:0];
            end
        end
    end

    // Receive side: field capture, length count, tail detect
    assign wpos     = byte_count_reg - 4'd2;
    assign field_we = is_rx && (byte_count_reg >= 4'd2) && (byte_count_reg <= 4'd5);
    assign is_tail  = (item.rx_byte == TAIL_BYTE);
    assign frame_ok = is_rx && is_tail && (byte_count_reg == 4'd6)
                   && (fields_reg[3] == (fields_reg[0] ^ fields_reg[1] ^ fields_reg[2]));

    always_comb
    begin
        cmd_en_class  = 1'b0;
        cmd_val_class = 1'b0;
        unique case (fields_reg[0])
            CMD_RADAR_EN_GET, CMD_RADAR_EN_SET, CMD_LIGHT_EN_GET, CMD_LIGHT_EN_SET:
                cmd_en_class = 1'b1;
            CMD_DIST_GET, CMD_DIST_SET, CMD_DELAY_GET, CMD_DELAY_SET,
            CMD_LIGHT_HI_GET, CMD_LIGHT_HI_SET, CMD_LIGHT_LO_GET, CMD_LIGHT_LO_SET:
                cmd_val_class = 1'b1;
            default:
            begin
                cmd_en_class  = 1'b0;
                cmd_val_class = 1'b0;
            end
        endcase
    end

    // State next values
    always_comb
    begin
        awaited_next    = awaited_reg;
        byte_count_next = byte_count_reg;
        if (is_req && op_ok)
        begin
            awaited_next = is_enable ? AWAIT_EN : AWAIT_VAL;
        end
        if (is_rx)
        begin
            if (is_tail)
            begin
                byte_count_next = 4'd0;
            end
            else if (byte_count_reg != COUNT_MAX)
            begin
                byte_count_next = byte_count_reg + 4'd1;
            end
        end
    end

    // Job for the emitter
    always_comb
    begin
        job          = '0;
        job.cmd      = req_cmd;
        job.arg_h    = req_h;
        job.arg_l    = req_l;
        job.chk      = req_cmd ^ req_h ^ req_l;
        job.enabled  = (fields_reg[2] == 8'd1);
        job.value    = {fields_reg[1], fields_reg[2]};
        if (is_req && op_ok)
        begin
            job.valid    = 1'b1;
            job.is_frame = 1'b1;
            job.kind     = KIND_TX;
        end
        else if (frame_ok && cmd_en_class && (awaited_reg == AWAIT_EN))
        begin
            job.valid = 1'b1;
            job.kind  = KIND_EN;
        end
        else if (frame_ok && cmd_val_class && (awaited_reg == AWAIT_VAL))
        begin
            job.valid = 1'b1;
            job.kind  = KIND_VAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_reg    <= AWAIT_NONE;
            byte_count_reg <= 4'd0;
        end
        else
        begin
            awaited_reg    <= awaited_next;
            byte_count_reg <= byte_count_next;
        end
    end

    // Frame fields: no reset, written before any accepted frame reads them
    always_ff @(posedge clk)
    begin
        if (field_we)
        begin
            fields_reg[wpos[1:0]] <= item.rx_byte;
        end
    end

    `RSLC_ASSERT_NEXT(a_tail_clears_count, clk, rst_n, is_rx && is_tail, byte_count_reg == 4'd0, "tail byte did not clear the byte count")
    `RSLC_ASSERT_NEXT(a_req_sets_await, clk, rst_n, is_req && op_ok, awaited_reg != AWAIT_NONE, "request left nothing awaited")
    `RSLC_ASSERT_NOW(a_answer_needs_frame, clk, rst_n, job.valid && !job.is_frame, frame_ok, "answer issued without a good frame")

endmodule

// ===== rtl/core/rslc_emitter.sv =====
// Emitter: holds one job and streams its beats into the result register.
`include "radar_sensor_link_codec_macros.svh"

module rslc_emitter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rslc_pkg::job_t         job,
    output rslc_pkg::emit_status_t status,
    output logic                  result_valid,
    input  logic                  result_stall,
    output rslc_pkg::result_t      result
);
    import rslc_pkg::*;

    job_t       job_reg;
    logic       job_valid_reg, job_valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg;
    result_t    out_reg;

    logic       load;
    logic       beat;
    logic       last;
    result_t    beat_data;

    assign load = !out_valid_reg || !result_stall;
    assign beat = job_valid_reg && load;
    assign last = !job_reg.is_frame || (idx_reg == LAST_IDX);
    assign status.free = !job_valid_reg || (beat && last);

    // Payload of the current beat
    always_comb
    begin
        beat_data              = '0;
        beat_data.out_kind     = job_reg.kind;
        if (job_reg.is_frame)
        begin
            beat_data.tx_last = (idx_reg == LAST_IDX);
            unique case (idx_reg)
                3'd0:    beat_data.tx_byte = HEAD0_BYTE;
                3'd1:    beat_data.tx_byte = HEAD1_BYTE;
                3'd2:    beat_data.tx_byte = job_reg.cmd;
                3'd3:    beat_data.tx_byte = job_reg.arg_h;
                3'd4:    beat_data.tx_byte = job_reg.arg_l;
                3'd5:    beat_data.tx_byte = job_reg.chk;
                default: beat_data.tx_byte = TAIL_BYTE;
            endcase
        end
        else if (job_reg.kind == KIND_EN)
        begin
            beat_data.enabled = job_reg.enabled;
        end
        else
        begin
            beat_data.answer_value = job_reg.value;
        end
    end

    // Job slot control
    always_comb
    begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        if (job.valid)
        begin
            job_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
        else if (beat && last)
        begin
            job_valid_next = 1'b0;
            idx_next       = 3'd0;
        end
        else if (beat)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            if (load)
            begin
                out_valid_reg <= job_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job.valid)
        begin
            job_reg <= job;
        end
        if (beat)
        begin
            out_reg <= beat_data;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `RSLC_ASSERT_NOW(a_job_into_free_slot, clk, rst_n, job.valid, status.free, "job loaded over a busy slot")
    `RSLC_ASSERT_NOW(a_idx_range, clk, rst_n, job_valid_reg, idx_reg <= LAST_IDX, "beat index past frame end")
    `RSLC_ASSERT_NOW(a_answer_single, clk, rst_n, job_valid_reg && !job_reg.is_frame, idx_reg == 3'd0, "answer job advanced its index")

endmodule

// ===== rtl/core/radar_sensor_link_codec.sv =====
// Top level of the radar/light sensor link codec, host side.
//
//  channel  | direction | payload  | handshake
//  item     | in        | item_t   | item_valid / item_stall
//  result   | out       | result_t | result_valid / result_stall
//
// A beat is decoded in the cycle it is accepted and lands in the job slot at that edge;
// its first result then moves into the output register whenever it can load. A request
// makes seven result beats, one per cycle while not stalled, from a single job slot; a
// received byte makes at most one. The slot takes the next beat in the cycle its last
// result moves into the output register, so unstalled single-result beats run 1/cycle.
// Reset clears the awaited answer kind, the frame byte count and all valid flags.
// While result_stall is high a valid output register holds and item_stall rises once
// the job slot is busy.

module radar_sensor_link_codec (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  rslc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output rslc_pkg::result_t result
);
    import rslc_pkg::*;

    job_t         job;
    emit_status_t status;
    logic         accept;

    assign item_stall = !status.free;
    assign accept     = item_valid && !item_stall;

    rslc_decoder u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .job    (job)
    );

    rslc_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
